// ===== rtl/core/bid_pkg.sv =====
// Shared widths, action codes and status codes of the bounded indexed deque.
`default_nettype none
package bid_pkg;

  // Transaction field widths
  localparam int ACTION_W = 4;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  // Scratch width for zero-extending stored words of any supported width
  localparam int EXT_W    = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_PEEK_FRONT = 4'd4,
    ACT_PEEK_BACK  = 4'd5,
    ACT_READ_AT    = 4'd6,
    ACT_INSERT_AT  = 4'd7,
    ACT_ERASE_AT   = 4'd8,
    ACT_CLEAR      = 4'd9
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bid_if.sv =====
// Valid/ready channel interfaces for requests and results of the deque.
`default_nettype none
interface bid_req_if;
  logic                         valid;
  logic                         ready;
  logic [bid_pkg::ACTION_W-1:0] action;
  logic [bid_pkg::POS_W-1:0]    position;
  logic [bid_pkg::WORD_W-1:0]   data_in;

  modport source (output valid, action, position, data_in, input ready);
  modport sink   (input valid, action, position, data_in, output ready);
endinterface

interface bid_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bid_pkg::WORD_W-1:0]   data_out;
  logic [bid_pkg::STATUS_W-1:0] status;
  logic [bid_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bounded_indexed_deque.sv =====
// Bounded indexed deque: circular entry store with end and positional access.
// Path, accept to result: push, clear, rejected or ignored requests and insert_at
//   at the back end go straight to the result; pops, peeks and read_at add a RAM read;
//   other insert_at first moves each entry at or behind the position, erase_at each one behind it.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset clears head and occupancy; stored words stay undefined until written.
`default_nettype none
module bounded_indexed_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  bid_req_if.sink  in_ch,
  bid_rsp_if.source out_ch
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bid_pkg::POS_W) ? CW : bid_pkg::POS_W;
  localparam int SW   = CMPW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ERASE_RD,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INS_WR,
    S_RESULT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 src_r, src_nxt;
  logic [AW-1:0]                 dst_r, dst_nxt;
  logic [AW-1:0]                 ins_r, ins_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0]         din_r, din_nxt;
  logic [bid_pkg::WORD_W-1:0]    res_data_r, res_data_nxt;
  bid_pkg::status_t              res_status_r, res_status_nxt;

  logic                          out_valid_r;
  logic [bid_pkg::WORD_W-1:0]    out_data_r;
  bid_pkg::status_t              out_status_r;
  logic [bid_pkg::OCC_W-1:0]     out_occ_r;

  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]         mem_wdata, mem_rdata;

  logic                          in_fire, out_load;
  bid_pkg::action_t              act;
  logic [CMPW-1:0]               pos_x, cnt_x, occ_x;
  logic [bid_pkg::EXT_W-1:0]     din_ext, rd_ext;
  logic [DATA_WIDTH-1:0]         din_w;
  logic [bid_pkg::WORD_W-1:0]    rd_word;
  logic                          is_full, is_empty;
  logic [AW-1:0]                 head_inc, head_dec, src_inc, src_dec;
  logic [AW-1:0]                 tail_slot, last_slot, pos_slot;
  logic [CMPW-1:0]               ins_moves, era_moves;

  // Circular slot of an entry index: base + idx, wrapped once
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CMPW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(idx);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

  bid_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Handshakes
  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_load        = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.occupancy = out_occ_r;

  // Word width adaption and address precompute
  always_comb begin
    act       = bid_pkg::action_t'(in_ch.action);
    din_ext   = bid_pkg::EXT_W'(in_ch.data_in);
    din_w     = din_ext[DATA_WIDTH-1:0];
    rd_ext    = '0;
    rd_ext[DATA_WIDTH-1:0] = mem_rdata;
    rd_word   = rd_ext[bid_pkg::WORD_W-1:0];
    pos_x     = CMPW'(in_ch.position);
    cnt_x     = CMPW'(count_r);
    occ_x     = CMPW'(count_r);
    is_full   = (count_r == CW'(DEPTH));
    is_empty  = (count_r == '0);
    head_inc  = wrap_inc(head_r);
    head_dec  = wrap_dec(head_r);
    src_inc   = wrap_inc(src_r);
    src_dec   = wrap_dec(src_r);
    tail_slot = slot_of(head_r, cnt_x);
    last_slot = wrap_dec(tail_slot);
    pos_slot  = slot_of(head_r, pos_x);
    ins_moves = cnt_x - pos_x;
    era_moves = cnt_x - pos_x - CMPW'(1);
  end

  // Request sequencing and RAM port control
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    ins_nxt        = ins_r;
    rem_nxt        = rem_r;
    din_nxt        = din_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = dst_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = src_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_data_nxt   = '0;
          res_status_nxt = bid_pkg::STAT_OK;
          din_nxt        = din_w;
          state_nxt      = S_RESULT;
          unique case (act)
            bid_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                res_status_nxt = bid_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                mem_wdata = din_w;
                head_nxt  = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            bid_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                res_status_nxt = bid_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_slot;
                mem_wdata = din_w;
                count_nxt = count_r + CW'(1);
              end
            end
            bid_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            bid_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = last_slot;
                count_nxt = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            bid_pkg::ACT_PEEK_FRONT: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_RD;
              end
            end
            bid_pkg::ACT_PEEK_BACK: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = last_slot;
                state_nxt = S_RD;
              end
            end
            bid_pkg::ACT_READ_AT: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status_nxt = bid_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_slot;
                state_nxt = S_RD;
              end
            end
            bid_pkg::ACT_INSERT_AT: begin
              if (pos_x > cnt_x) begin
                res_status_nxt = bid_pkg::STAT_RANGE;
              end else if (is_full) begin
                res_status_nxt = bid_pkg::STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
                if (ins_moves == '0) begin
                  // append at the back end: no entries to move
                  mem_we    = 1'b1;
                  mem_waddr = pos_slot;
                  mem_wdata = din_w;
                end else begin
                  // move entries up one slot, last first
                  mem_re    = 1'b1;
                  mem_raddr = last_slot;
                  src_nxt   = last_slot;
                  dst_nxt   = tail_slot;
                  ins_nxt   = pos_slot;
                  rem_nxt   = ins_moves[CW-1:0];
                  state_nxt = S_SHIFT_UP;
                end
              end
            end
            bid_pkg::ACT_ERASE_AT: begin
              if (is_empty) begin
                res_status_nxt = bid_pkg::STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status_nxt = bid_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_slot;
                src_nxt   = pos_slot;
                rem_nxt   = era_moves[CW-1:0];
                count_nxt = count_r - CW'(1);
                state_nxt = S_ERASE_RD;
              end
            end
            bid_pkg::ACT_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
              // unknown action: no effect
            end
          endcase
        end
      end

      S_RD: begin
        res_data_nxt = rd_word;
        state_nxt    = S_RESULT;
      end

      // Removed word arrives; start pulling later entries down
      S_ERASE_RD: begin
        res_data_nxt = rd_word;
        if (rem_r == '0) begin
          state_nxt = S_RESULT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = src_inc;
          dst_nxt   = src_r;
          src_nxt   = src_inc;
          state_nxt = S_SHIFT_DN;
        end
      end

      // Write the entry just read one slot toward the front, read the next
      S_SHIFT_DN: begin
        mem_we  = 1'b1;
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = S_RESULT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = src_inc;
          dst_nxt   = src_r;
          src_nxt   = src_inc;
        end
      end

      // Write the entry just read one slot toward the back, read the previous
      S_SHIFT_UP: begin
        mem_we  = 1'b1;
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = S_INS_WR;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = src_dec;
          dst_nxt   = src_r;
          src_nxt   = src_dec;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_r;
        mem_wdata = din_r;
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, pointers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    ins_r        <= ins_nxt;
    din_r        <= din_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
      out_occ_r    <= occ_x[bid_pkg::OCC_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bid_ram.sv =====
// Entry storage: one write port, one registered read port.
`default_nettype none
module bid_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [DATA_WIDTH-1:0]         wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output      logic [DATA_WIDTH-1:0]         rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
